/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the detector's core RTL. The including module
// must have aclk and aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a plain expression at every clock edge outside reset.
`define DD_ASSERT(name, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define DD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dd_pkg.sv */
// ----------------------------------------------------------------------------
// dd_pkg
// Request and result types, request kinds and shared unit operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dd_pkg;

    localparam logic [1:0] KIND_HELD   = 2'd0;
    localparam logic [1:0] KIND_WANTED = 2'd1;
    localparam logic [1:0] KIND_FREE   = 2'd2;
    localparam logic [1:0] KIND_RUN    = 2'd3;

    localparam logic [1:0] OP_NONZERO = 2'd0;
    localparam logic [1:0] OP_EXCEEDS = 2'd1;
    localparam logic [1:0] OP_SATADD  = 2'd2;

    localparam logic REG_PROCESS_COUNT  = 1'b0;
    localparam logic REG_RESOURCE_COUNT = 1'b1;

    localparam int PCOUNT_W = 5;
    localparam int RCOUNT_W = 4;
    localparam int AMOUNT_W = 8;
    localparam int FREE_W   = 16;

    typedef struct packed {
        logic [1:0]          kind;
        logic [3:0]          process_index;
        logic [2:0]          resource_index;
        logic [AMOUNT_W-1:0] amount;
    } dd_req_t;

    typedef struct packed {
        logic [3:0] proc_id;
        logic       deadlocked;
        logic       last_result;
    } dd_res_t;

    typedef struct packed {
        logic              flag;
        logic [FREE_W-1:0] sum;
    } dd_alu_out_t;

endpackage

`default_nettype wire

/* rtl/core/dd_alu.sv */
// ----------------------------------------------------------------------------
// dd_alu
// Shared compare and saturating add unit used by every sweep phase.
// ----------------------------------------------------------------------------
`default_nettype none

module dd_alu import dd_pkg::*; (
    input  wire logic [1:0]          op,
    input  wire logic [FREE_W-1:0]   free_val,
    input  wire logic [AMOUNT_W-1:0] operand,
    output dd_alu_out_t              result
);

    logic [FREE_W:0] wide_sum;

    assign wide_sum = {1'b0, free_val} + (FREE_W + 1)'(operand);

    always_comb begin
        result.sum = wide_sum[FREE_W] ? {FREE_W{1'b1}} : wide_sum[FREE_W-1:0];
        case (op)
            OP_NONZERO: result.flag = (operand != '0);
            OP_EXCEEDS: result.flag = (FREE_W'(operand) > free_val);
            default:    result.flag = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/dd_store.sv */
// ----------------------------------------------------------------------------
// dd_store
// Allocation, request and available memories with registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module dd_store import dd_pkg::*; #(
    parameter int MAX_PROCS     = 16,
    parameter int MAX_RESOURCES = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 ld_en,
    input  dd_req_t                   ld_req,
    input  wire logic [PW-1:0]        rd_p,
    input  wire logic [RW-1:0]        rd_r,
    input  wire logic                 sw_wr_en,
    input  wire logic [RW-1:0]        sw_wr_r,
    input  wire logic [FREE_W-1:0]    sw_wr_data,
    output logic      [AMOUNT_W-1:0]  held_q,
    output logic      [AMOUNT_W-1:0]  wanted_q,
    output logic      [FREE_W-1:0]    free_q
);

    localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int DEPTH = MAX_PROCS * MAX_RESOURCES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [AMOUNT_W-1:0] held_mem   [DEPTH];
    logic [AMOUNT_W-1:0] wanted_mem [DEPTH];
    logic [FREE_W-1:0]   free_mem   [MAX_RESOURCES];

    logic          p_ok;
    logic          r_ok;
    logic [AW-1:0] ld_idx;
    logic [AW-1:0] rd_idx;
    logic          free_we;
    logic [RW-1:0] free_wa;
    logic [FREE_W-1:0] free_wd;

    assign p_ok   = (32'(ld_req.process_index) < MAX_PROCS);
    assign r_ok   = (32'(ld_req.resource_index) < MAX_RESOURCES);
    assign ld_idx = AW'(32'(ld_req.process_index) * MAX_RESOURCES
                        + 32'(ld_req.resource_index));
    assign rd_idx = AW'(32'(rd_p) * MAX_RESOURCES + 32'(rd_r));

    // Loads only arrive while no sweep runs, so the two writers never collide.
    always_comb begin
        free_we = sw_wr_en;
        free_wa = sw_wr_r;
        free_wd = sw_wr_data;
        if (ld_en && (ld_req.kind == KIND_FREE) && r_ok) begin
            free_we = 1'b1;
            free_wa = RW'(ld_req.resource_index);
            free_wd = FREE_W'(ld_req.amount);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_en && (ld_req.kind == KIND_HELD) && p_ok && r_ok) begin
            held_mem[ld_idx] <= ld_req.amount;
        end
        held_q <= held_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (ld_en && (ld_req.kind == KIND_WANTED) && p_ok && r_ok) begin
            wanted_mem[ld_idx] <= ld_req.amount;
        end
        wanted_q <= wanted_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (free_we) begin
            free_mem[free_wa] <= free_wd;
        end
        free_q <= free_mem[rd_r];
    end

endmodule

`default_nettype wire

/* rtl/core/dd_seq.sv */
// ----------------------------------------------------------------------------
// dd_seq
// Sweep sequencer: walks processes and resources through the shared unit,
// keeps the finished flags and hands out one result per process.
// ----------------------------------------------------------------------------
`default_nettype none

module dd_seq import dd_pkg::*; #(
    parameter int MAX_PROCS     = 16,
    parameter int MAX_RESOURCES = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [PCW-1:0]       np,
    input  wire logic [RCW-1:0]       nr,
    input  wire logic [AMOUNT_W-1:0]  held_q,
    input  wire logic [AMOUNT_W-1:0]  wanted_q,
    input  wire logic [FREE_W-1:0]    free_q,
    output logic      [PW-1:0]        rd_p,
    output logic      [RW-1:0]        rd_r,
    output logic                      wr_en,
    output logic      [RW-1:0]        wr_r,
    output logic      [FREE_W-1:0]    wr_data,
    output logic                      res_valid,
    output dd_res_t                   res,
    input  wire logic                 res_take,
    output logic                      busy
);

    localparam int PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int PCW = $clog2(MAX_PROCS + 1);
    localparam int RCW = $clog2(MAX_RESOURCES + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HOLD   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_GIVE   = 3'd3;
    localparam logic [2:0] S_REPORT = 3'd4;

    logic [2:0]           state_reg,    state_next;
    logic [PW-1:0]        p_reg,        p_next;
    logic [RCW-1:0]       r_reg,        r_next;
    logic                 pend_reg,     pend_next;
    logic                 last_reg,     last_next;
    logic [RW-1:0]        pend_r_reg,   pend_r_next;
    logic                 acc_reg,      acc_next;
    logic                 progress_reg, progress_next;
    logic [MAX_PROCS-1:0] done_reg,     done_next;

    logic [1:0]          alu_op;
    logic [AMOUNT_W-1:0] alu_b;
    dd_alu_out_t         alu_out;
    logic                acc_d;
    logic                p_last;
    logic                advance;
    logic                adv_prog;

    dd_alu u_alu (
        .op       (alu_op),
        .free_val (free_q),
        .operand  (alu_b),
        .result   (alu_out)
    );

    assign p_last = (PCW'(p_reg) == (np - PCW'(1)));
    assign rd_p   = p_reg;
    assign rd_r   = r_reg[RW-1:0];
    assign wr_r   = pend_r_reg;
    assign wr_data = alu_out.sum;
    assign busy   = (state_reg != S_IDLE);

    assign res.proc_id     = 4'(p_reg);
    assign res.deadlocked  = ~done_reg[p_reg];
    assign res.last_result = p_last;

    always_comb begin
        case (state_reg)
            S_CHECK: begin
                alu_op = OP_EXCEEDS;
                alu_b  = wanted_q;
            end
            S_GIVE: begin
                alu_op = OP_SATADD;
                alu_b  = held_q;
            end
            default: begin
                alu_op = OP_NONZERO;
                alu_b  = held_q;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        p_next        = p_reg;
        r_next        = r_reg;
        pend_next     = 1'b0;
        last_next     = last_reg;
        pend_r_next   = pend_r_reg;
        acc_next      = acc_reg;
        progress_next = progress_reg;
        done_next     = done_reg;
        wr_en         = 1'b0;
        res_valid     = 1'b0;
        acc_d         = acc_reg;
        advance       = 1'b0;
        adv_prog      = progress_reg;

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_HOLD;
                    p_next     = '0;
                    r_next     = '0;
                    acc_next   = 1'b0;
                end
            end
            S_HOLD, S_CHECK, S_GIVE: begin
                if ((state_reg == S_CHECK) && done_reg[p_reg]) begin
                    advance = 1'b1;
                end else begin
                    // Issue the next read while the previous one is evaluated.
                    if (r_reg < nr) begin
                        r_next      = r_reg + RCW'(1);
                        pend_next   = 1'b1;
                        last_next   = (r_reg == (nr - RCW'(1)));
                        pend_r_next = r_reg[RW-1:0];
                    end
                    if (pend_reg) begin
                        case (state_reg)
                            S_HOLD:  acc_d = acc_reg | alu_out.flag;
                            S_CHECK: acc_d = acc_reg & ~alu_out.flag;
                            default: begin
                                acc_d = acc_reg;
                                wr_en = 1'b1;
                            end
                        endcase
                        acc_next = acc_d;
                        if (last_reg) begin
                            r_next = '0;
                            case (state_reg)
                                S_HOLD: begin
                                    done_next[p_reg] = ~acc_d;
                                    if (p_last) begin
                                        state_next    = S_CHECK;
                                        p_next        = '0;
                                        progress_next = 1'b0;
                                        acc_next      = 1'b1;
                                    end else begin
                                        p_next   = p_reg + PW'(1);
                                        acc_next = 1'b0;
                                    end
                                end
                                S_CHECK: begin
                                    if (acc_d) begin
                                        state_next = S_GIVE;
                                    end else begin
                                        advance = 1'b1;
                                    end
                                end
                                default: begin
                                    done_next[p_reg] = 1'b1;
                                    advance          = 1'b1;
                                    adv_prog         = 1'b1;
                                end
                            endcase
                        end
                    end
                end
            end
            S_REPORT: begin
                res_valid = 1'b1;
                if (res_take) begin
                    if (p_last) begin
                        state_next = S_IDLE;
                    end else begin
                        p_next = p_reg + PW'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (advance) begin
            r_next    = '0;
            acc_next  = 1'b1;
            pend_next = 1'b0;
            if (p_last) begin
                p_next        = '0;
                progress_next = 1'b0;
                state_next    = adv_prog ? S_CHECK : S_REPORT;
            end else begin
                p_next        = p_reg + PW'(1);
                progress_next = adv_prog;
                state_next    = S_CHECK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            p_reg        <= '0;
            r_reg        <= '0;
            pend_reg     <= 1'b0;
            last_reg     <= 1'b0;
            acc_reg      <= 1'b0;
            progress_reg <= 1'b0;
            done_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            p_reg        <= p_next;
            r_reg        <= r_next;
            pend_reg     <= pend_next;
            last_reg     <= last_next;
            acc_reg      <= acc_next;
            progress_reg <= progress_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_r_reg <= pend_r_next;
    end

endmodule

`default_nettype wire

/* rtl/core/deadlock_detector_core.sv */
// ----------------------------------------------------------------------------
// deadlock_detector_core
// Resource deadlock detector over loaded allocation and request matrices.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                       Moves
//  -------   -------------------------   --------------------------------------
//  s_        s_valid s_ready s_req       load request or run request
//  m_        m_valid m_ready m_res       one result per process after a run
//  APB       psel penable pwrite paddr   process_count (0x0), resource_count (0x4)
//
//  A load request is accepted back to back.
//  A run request holds s_ready low until its last result has left the
//  sequencer. It scans the holdings, then sweeps in passes that skip
//  finished processes, check the others and let each one that fits give
//  back; passes repeat while a pass finishes a process. Then one result per
//  cycle leaves. The single shared compare/add unit and the single read
//  port of each memory set the pace. A stalled m_ready only stalls the
//  reporting. Reset clears control state; the memories are not cleared.
//
`default_nettype none

`include "assert_macros.svh"

module deadlock_detector_core import dd_pkg::*; #(
    parameter int MAX_PROCS     = 16,
    parameter int MAX_RESOURCES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  dd_req_t          s_req,

    output logic             m_valid,
    input  wire logic        m_ready,
    output dd_res_t          m_res,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int PCW = $clog2(MAX_PROCS + 1);
    localparam int RCW = $clog2(MAX_RESOURCES + 1);

    // Configuration registers. They keep the value written; the counts that
    // the sweep uses are clamped into the supported range below.
    logic [PCOUNT_W-1:0] pcount_reg;
    logic [RCOUNT_W-1:0] rcount_reg;
    logic                cfg_wr;

    logic [PCW-1:0] np;
    logic [RCW-1:0] nr;

    logic accept;
    logic seq_busy;

    logic [PW-1:0]       rd_p;
    logic [RW-1:0]       rd_r;
    logic                free_wr_en;
    logic [RW-1:0]       free_wr_r;
    logic [FREE_W-1:0]   free_wr_data;
    logic [AMOUNT_W-1:0] held_q;
    logic [AMOUNT_W-1:0] wanted_q;
    logic [FREE_W-1:0]   free_q;

    logic    res_valid;
    logic    res_take;
    dd_res_t res;

    // Output register. It separates the sequencer from the result channel so
    // that one finished result can wait while the next one is lined up.
    logic    m_valid_reg;
    dd_res_t m_res_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg <= PCOUNT_W'(16);
            rcount_reg <= RCOUNT_W'(8);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_PROCESS_COUNT:  pcount_reg <= pwdata[PCOUNT_W-1:0];
                REG_RESOURCE_COUNT: rcount_reg <= pwdata[RCOUNT_W-1:0];
                default:            pcount_reg <= pcount_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PROCESS_COUNT:  prdata = 32'(pcount_reg);
            REG_RESOURCE_COUNT: prdata = 32'(rcount_reg);
            default:            prdata = '0;
        endcase
    end

    // A zero count runs as one; a count above the build maximum runs as the
    // maximum.
    always_comb begin
        if (pcount_reg == '0) begin
            np = PCW'(1);
        end else if (32'(pcount_reg) > MAX_PROCS) begin
            np = PCW'(MAX_PROCS);
        end else begin
            np = PCW'(pcount_reg);
        end
        if (rcount_reg == '0) begin
            nr = RCW'(1);
        end else if (32'(rcount_reg) > MAX_RESOURCES) begin
            nr = RCW'(MAX_RESOURCES);
        end else begin
            nr = RCW'(rcount_reg);
        end
    end

    // Requests are taken whenever the sequencer is idle. Loads write the
    // memories directly; a run request starts the sequencer.
    assign s_ready = ~seq_busy;
    assign accept  = s_valid && s_ready;

    dd_store #(
        .MAX_PROCS     (MAX_PROCS),
        .MAX_RESOURCES (MAX_RESOURCES)
    ) u_store (
        .aclk       (aclk),
        .ld_en      (accept),
        .ld_req     (s_req),
        .rd_p       (rd_p),
        .rd_r       (rd_r),
        .sw_wr_en   (free_wr_en),
        .sw_wr_r    (free_wr_r),
        .sw_wr_data (free_wr_data),
        .held_q     (held_q),
        .wanted_q   (wanted_q),
        .free_q     (free_q)
    );

    dd_seq #(
        .MAX_PROCS     (MAX_PROCS),
        .MAX_RESOURCES (MAX_RESOURCES)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept && (s_req.kind == KIND_RUN)),
        .np        (np),
        .nr        (nr),
        .held_q    (held_q),
        .wanted_q  (wanted_q),
        .free_q    (free_q),
        .rd_p      (rd_p),
        .rd_r      (rd_r),
        .wr_en     (free_wr_en),
        .wr_r      (free_wr_r),
        .wr_data   (free_wr_data),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .busy      (seq_busy)
    );

    // The output register takes a new result when it is empty or when its
    // current result leaves in the same cycle.
    assign res_take = ~m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_take) begin
            m_res_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    // A run request must wake the sequencer in the following cycle.
    `DD_ASSERT_NEXT(a_run_starts, accept && (s_req.kind == KIND_RUN), seq_busy, "run request did not start the sequencer")

    // Handing over the final result returns the sequencer to idle.
    `DD_ASSERT_NEXT(a_last_ends, res_valid && res_take && res.last_result, !seq_busy, "sequencer stayed busy after the final result")

    // The sweep rewrites the available counts only while it runs, not while reporting.
    `DD_ASSERT(a_give_busy, !free_wr_en || (seq_busy && !res_valid), "available count written outside a sweep")

endmodule

`default_nettype wire
